// ----- src/bbu_pkg.sv -----
// ----------------------------------------------------------------------------
// bbu_pkg
// Shared types and constants for the bit-aligned bitmap unpacker.
// ----------------------------------------------------------------------------
package bbu_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_ROWS  = 2'd2;

  localparam logic       MODE_PASS = 1'b0;
  localparam logic       MODE_BITS = 1'b1;

  localparam logic       RST_MODE  = MODE_BITS;
  localparam logic [7:0] RST_WIDTH = 8'd8;
  localparam logic [7:0] RST_ROWS  = 8'd8;

  localparam logic [2:0] LAST_RESULT = 3'd7;  // eighth result of one word
  localparam logic [3:0] BYTE_BITS   = 4'd8;

  // register contents plus effective (zero-as-one) values
  typedef struct packed {
    logic       mode;
    logic [7:0] width;
    logic [7:0] rows;
    logic [7:0] eff_width;
    logic [7:0] eff_rows;
    logic       restart;
  } cfg_t;

  typedef struct packed {
    logic load;   // latch the accepted input word
    logic step;   // produce one result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic last;   // result in the output register is the last of its word
  } dp_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_STEP = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

endpackage

// ----- src/bit_aligned_bitmap_unpacker_core.sv -----
// ----------------------------------------------------------------------------
// bit_aligned_bitmap_unpacker_core
// Repacks glyph bitmap bytes into byte-aligned rows, MSB first.
// ----------------------------------------------------------------------------
// Flow: an accepted word passes through ST_STEP, which loads the output
//   register, and its results then show in ST_OUT; a word yields n results
//   (n = 1..8), which leave at one per cycle while m_axis_tready is high; a
//   new word is taken only as the last result of the old one leaves.
// Reset: rst_ni async, active low; registers return to bit-aligned mode,
//   width 8, height 8, accumulator empty. No clearing pass.
// ----------------------------------------------------------------------------
module bit_aligned_bitmap_unpacker_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] src_byte
  // output stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]                 m_axis_tuser,   // [0] row_end, [1] glyph_end
  output logic                       m_axis_tlast,   // run_last
  // APB configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bbu_pkg::ADDR_W-1:0] paddr,
  input  logic [bbu_pkg::DATA_W-1:0] pwdata,
  output logic [bbu_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import bbu_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // register file; any write to a listed register restarts the glyph
  bbu_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: idle -> step -> out, looping out->out while the word has bits
  bbu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // accumulator, counters and the output register
  bbu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .src_byte_i  (s_axis_tdata),
    .sts_o       (sts),
    .out_byte_o  (m_axis_tdata),
    .row_end_o   (m_axis_tuser[0]),
    .glyph_end_o (m_axis_tuser[1]),
    .run_last_o  (m_axis_tlast)
  );

endmodule

// ----- src/bbu_regs.sv -----
// ----------------------------------------------------------------------------
// bbu_regs
// APB register file: packing mode, row width and row count.
// ----------------------------------------------------------------------------
module bbu_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bbu_pkg::ADDR_W-1:0] paddr,
  input  logic [bbu_pkg::DATA_W-1:0] pwdata,
  output logic [bbu_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output bbu_pkg::cfg_t              cfg_o
);
  import bbu_pkg::*;

  logic       mode_q, mode_d;
  logic [7:0] width_q, width_d;
  logic [7:0] rows_q, rows_d;
  logic       wr_en;
  logic       hit;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    mode_d  = mode_q;
    width_d = width_q;
    rows_d  = rows_q;
    hit     = 1'b0;
    if (wr_en) begin
      unique case (idx)
        REG_MODE: begin
          mode_d = pwdata[0];
          hit    = 1'b1;
        end
        REG_WIDTH: begin
          width_d = pwdata[7:0];
          hit     = 1'b1;
        end
        REG_ROWS: begin
          rows_d = pwdata[7:0];
          hit    = 1'b1;
        end
        default: hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= RST_MODE;
      width_q <= RST_WIDTH;
      rows_q  <= RST_ROWS;
    end else begin
      mode_q  <= mode_d;
      width_q <= width_d;
      rows_q  <= rows_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:  prdata = {31'd0, mode_q};
      REG_WIDTH: prdata = {24'd0, width_q};
      REG_ROWS:  prdata = {24'd0, rows_q};
      default:   prdata = '0;
    endcase
  end

  // effective sizes follow the value being written so a restart reloads the new one
  assign cfg_o.mode      = mode_q;
  assign cfg_o.width     = width_q;
  assign cfg_o.rows      = rows_q;
  assign cfg_o.eff_width = (width_d == 8'd0) ? 8'd1 : width_d;
  assign cfg_o.eff_rows  = (rows_d == 8'd0) ? 8'd1 : rows_d;
  assign cfg_o.restart   = hit;

endmodule

// ----- src/bbu_ctrl.sv -----
// ----------------------------------------------------------------------------
// bbu_ctrl
// Handshake controller: accept a word, step results out one at a time.
// ----------------------------------------------------------------------------
module bbu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  bbu_pkg::dp_sts_t sts_i,
  output bbu_pkg::dp_cmd_t cmd_o
);
  import bbu_pkg::*;

  state_e state_q, state_d;
  logic   take;

  // new word only once the last result of the old one leaves
  assign in_ready_o  = (state_q == ST_IDLE) ||
                       ((state_q == ST_OUT) && sts_i.last && out_ready_i);
  assign out_valid_o = (state_q == ST_OUT);
  assign take        = in_valid_i && in_ready_o;

  assign cmd_o.load = take;
  assign cmd_o.step = (state_q == ST_STEP) ||
                      ((state_q == ST_OUT) && out_ready_i && !sts_i.last);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (take) state_d = ST_STEP;
      ST_STEP: state_d = ST_OUT;
      ST_OUT: begin
        if (out_ready_i && sts_i.last) begin
          state_d = take ? ST_STEP : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/bbu_dp.sv -----
// ----------------------------------------------------------------------------
// bbu_dp
// Datapath: bit accumulator, row and glyph counters, output register.
// ----------------------------------------------------------------------------
module bbu_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bbu_pkg::cfg_t    cfg_i,
  input  bbu_pkg::dp_cmd_t cmd_i,
  input  logic [7:0]       src_byte_i,
  output bbu_pkg::dp_sts_t sts_o,
  output logic [7:0]       out_byte_o,
  output logic             row_end_o,
  output logic             glyph_end_o,
  output logic             run_last_o
);
  import bbu_pkg::*;

  logic [14:0] acc_q, acc_d;
  logic [3:0]  pend_q, pend_d;
  logic [7:0]  rbl_q, rbl_d;
  logic [7:0]  rows_q, rows_d;
  logic [2:0]  cnt_q, cnt_d;

  logic [7:0]  obyte_q;
  logic        rend_q, gend_q, last_q;

  logic [3:0]  need, nxt_need;
  logic [7:0]  mask;
  logic [22:0] win;
  logic [7:0]  chunk;
  logic [3:0]  pend_rem;
  logic [14:0] acc_rem;
  logic [7:0]  rbl_rem, rows_dec;
  logic        row_done, glyph_done, more;
  logic [14:0] st_acc;
  logic [3:0]  st_pend;
  logic [7:0]  st_rbl, st_rows;

  // one result: take min(row bits left, 8) bits off the top of the pending bits
  assign need  = (rbl_q < 8'd8) ? rbl_q[3:0] : BYTE_BITS;
  assign mask  = 8'(8'hFF << (BYTE_BITS - need));
  assign win   = {acc_q, 8'd0};
  assign chunk = (cfg_i.mode == MODE_BITS) ? (8'(win >> pend_q) & mask)
                                           : (acc_q[7:0] & mask);

  assign pend_rem   = pend_q - need;
  assign acc_rem    = acc_q & ~(15'h7FFF << pend_rem);
  assign rbl_rem    = rbl_q - {4'd0, need};
  assign rows_dec   = rows_q - 8'd1;
  assign row_done   = (rbl_rem == 8'd0);
  assign glyph_done = row_done && (rows_dec == 8'd0);

  always_comb begin
    st_acc  = (cfg_i.mode == MODE_BITS) ? acc_rem : 15'd0;
    st_pend = (cfg_i.mode == MODE_BITS) ? pend_rem : 4'd0;
    st_rbl  = rbl_rem;
    st_rows = rows_q;
    if (glyph_done) begin
      st_acc  = 15'd0;
      st_pend = 4'd0;
      st_rbl  = cfg_i.eff_width;
      st_rows = cfg_i.eff_rows;
    end else if (row_done) begin
      st_rbl  = cfg_i.eff_width;
      st_rows = rows_dec;
    end
  end

  // look ahead: does the same word yield another result?
  assign nxt_need = (st_rbl < 8'd8) ? st_rbl[3:0] : BYTE_BITS;
  assign more     = (cfg_i.mode == MODE_BITS) && (cnt_q != LAST_RESULT) &&
                    (st_pend >= nxt_need);

  always_comb begin
    acc_d  = acc_q;
    pend_d = pend_q;
    rbl_d  = rbl_q;
    rows_d = rows_q;
    cnt_d  = cnt_q;
    priority if (cfg_i.restart) begin
      acc_d  = 15'd0;
      pend_d = 4'd0;
      rbl_d  = cfg_i.eff_width;
      rows_d = cfg_i.eff_rows;
    end else if (cmd_i.load) begin
      cnt_d = 3'd0;
      if (cfg_i.mode == MODE_BITS) begin
        acc_d  = {acc_q[6:0], src_byte_i};  // at most 7 bits carried over
        pend_d = pend_q + BYTE_BITS;
      end else begin
        acc_d  = {7'd0, src_byte_i};
      end
    end else if (cmd_i.step) begin
      acc_d  = st_acc;
      pend_d = st_pend;
      rbl_d  = st_rbl;
      rows_d = st_rows;
      cnt_d  = cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= 15'd0;
      pend_q <= 4'd0;
      rbl_q  <= RST_WIDTH;
      rows_q <= RST_ROWS;
      cnt_q  <= 3'd0;
      last_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
      rbl_q  <= rbl_d;
      rows_q <= rows_d;
      cnt_q  <= cnt_d;
      if (cmd_i.step) begin
        last_q <= !more;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      obyte_q <= chunk;
      rend_q  <= row_done;
      gend_q  <= glyph_done;
    end
  end

  assign sts_o.last  = last_q;
  assign out_byte_o  = obyte_q;
  assign row_end_o   = rend_q;
  assign glyph_end_o = gend_q;
  assign run_last_o  = last_q;

endmodule

// ----- src/bbu_checker.sv -----
// ----------------------------------------------------------------------------
// bbu_checker
// Port-level checks for the unpacker, bound to the top level.
// ----------------------------------------------------------------------------
module bbu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // glyph end only on a row end
  a_gend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("glyph end without row end");

  // a new word enters only as the last result of the previous one leaves
  a_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast && m_axis_tready)
    else $error("input taken while results remain");

  // one word at a time: no accept right after an accept
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
    else $error("back-to-back accept");

endmodule

bind bit_aligned_bitmap_unpacker_core bbu_checker u_bbu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
